### rtl/core/cspg_pkg.sv
// Shared types and constants for the cardinal spline point generator.
// Used by every module under rtl/core; depends on nothing else.
package cspg_pkg;

    localparam int MAX_SEGMENT_POINTS_DEF = 64;
    localparam int COORD_W = 16;
    localparam int FRAC_BITS = 14;
    localparam int SCALE_W = 17;
    localparam int TAN_W = 34;
    localparam int KW = 40;
    localparam int ACC_W = 64;
    localparam int QUOT_W = 24;
    localparam int QUEUE_DEPTH = 2;
    localparam int NUM_LANES = 2;
    localparam int CFG_W = 16;

    localparam logic [15:0] TENSION_RESET = 16'd8192;
    localparam logic [6:0] PPS_RESET = 7'd16;
    localparam logic signed [SCALE_W-1:0] ONE_Q14 = 17'sd16384;

    typedef enum logic [0:0] {
        REG_TENSION            = 1'b0,
        REG_POINTS_PER_SEGMENT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic                      start_new;
    } in_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] pixel_x;
        logic signed [COORD_W-1:0] pixel_y;
        logic                      segment_end;
    } out_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } point_t;

    typedef struct packed {
        point_t a;
        point_t b;
        point_t c;
        point_t e;
    } job_t;

endpackage

### rtl/core/cspg_front.sv
// Front end: accepts control points, keeps the last three and queues segment jobs.
// Depends on cspg_pkg.
module cspg_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  cspg_pkg::in_item_t in_data,
    input  logic              seg_enable,
    input  logic              q_full,
    output logic              q_push,
    output cspg_pkg::job_t    q_job
);
    import cspg_pkg::*;

    point_t     hist_reg [3];
    logic [1:0] seen_reg;
    logic [1:0] seen_eff;
    point_t     hist_eff [3];
    point_t     new_pt;
    logic       accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign new_pt   = '{y: in_data.point_y, x: in_data.point_x};

    always_comb
    begin
        seen_eff = in_data.start_new ? 2'd0 : seen_reg;
        for (int i = 0; i < 3; i++)
        begin
            hist_eff[i] = in_data.start_new ? '0 : hist_reg[i];
        end
    end

    assign q_push = accept && (seen_eff == 2'd3) && seg_enable;
    assign q_job  = '{a: hist_eff[2], b: hist_eff[1], c: hist_eff[0], e: new_pt};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= 2'd0;
            for (int i = 0; i < 3; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else if (accept)
        begin
            hist_reg[2] <= hist_eff[1];
            hist_reg[1] <= hist_eff[0];
            hist_reg[0] <= new_pt;
            seen_reg    <= (seen_eff == 2'd3) ? 2'd3 : seen_eff + 2'd1;
        end
    end

endmodule

### rtl/core/cspg_queue.sv
// Short job queue between the front end and the evaluation back end.
// Depends on cspg_pkg.
module cspg_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  cspg_pkg::job_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output cspg_pkg::job_t pop_data
);
    import cspg_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    job_t          mem_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign full      = (count_reg == CW'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### rtl/core/cspg_divider.sv
// Restoring divider, one quotient bit per cycle, for the rounding division.
// Depends on cspg_pkg.
module cspg_divider (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [cspg_pkg::ACC_W-1:0]   dividend,
    input  logic [cspg_pkg::ACC_W-1:0]   divisor,
    output logic [cspg_pkg::QUOT_W-1:0]  quotient,
    output logic                         done
);
    import cspg_pkg::*;

    localparam int CNT_W = $clog2(QUOT_W + 1);

    logic [ACC_W-1:0]  rem_reg;
    logic [ACC_W-1:0]  dsh_reg;
    logic [QUOT_W-1:0] quot_reg;
    logic [CNT_W-1:0]  cnt_reg;

    assign quotient = quot_reg;
    assign done     = (cnt_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CNT_W'(QUOT_W);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= dividend;
            dsh_reg  <= divisor << (QUOT_W - 1);
            quot_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            if (rem_reg >= dsh_reg)
            begin
                rem_reg  <= rem_reg - dsh_reg;
                quot_reg <= {quot_reg[QUOT_W-2:0], 1'b1};
            end
            else
            begin
                quot_reg <= {quot_reg[QUOT_W-2:0], 1'b0};
            end
            dsh_reg <= dsh_reg >> 1;
        end
    end

endmodule

### rtl/core/cspg_back.sv
// Back end: evaluates each queued Hermite segment point by point, x and y in two lanes.
// Depends on cspg_pkg and cspg_divider.
module cspg_back #(
    parameter int MAX_SEGMENT_POINTS = cspg_pkg::MAX_SEGMENT_POINTS_DEF
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         q_valid,
    output logic                                         q_pop,
    input  cspg_pkg::job_t                               q_job,
    input  logic signed [cspg_pkg::SCALE_W-1:0]          scale,
    input  logic [$clog2(MAX_SEGMENT_POINTS)-1:0]        d,
    output logic                                         out_valid,
    input  logic                                         out_ready,
    output cspg_pkg::out_item_t                          out_data
);
    import cspg_pkg::*;

    localparam int DW = $clog2(MAX_SEGMENT_POINTS);
    localparam int PW = COORD_W + FRAC_BITS;

    typedef enum logic [3:0] {
        S_IDLE,
        S_D2,
        S_D3,
        S_TAN,
        S_COEF,
        S_PRE,
        S_H1,
        S_H2,
        S_H3,
        S_DSTART,
        S_DWAIT,
        S_EMIT
    } state_t;

    state_t                   state_reg;
    job_t                     job_reg;
    logic [2*DW-1:0]          d2_reg;
    logic [3*DW-1:0]          d3_reg;
    logic [DW-1:0]            j_reg;
    out_item_t                out_data_reg;
    logic                     out_valid_reg;

    logic signed [TAN_W-1:0]  t0_reg    [NUM_LANES];
    logic signed [TAN_W-1:0]  t1_reg    [NUM_LANES];
    logic signed [KW-1:0]     k3_reg    [NUM_LANES];
    logic signed [KW-1:0]     k2_reg    [NUM_LANES];
    logic signed [ACC_W-1:0]  k2d_reg   [NUM_LANES];
    logic signed [ACC_W-1:0]  t0dd_reg  [NUM_LANES];
    logic signed [ACC_W-1:0]  p0ddd_reg [NUM_LANES];
    logic signed [ACC_W-1:0]  acc_reg   [NUM_LANES];
    logic                     neg_reg   [NUM_LANES];

    logic signed [COORD_W-1:0] ca [NUM_LANES];
    logic signed [COORD_W-1:0] cb [NUM_LANES];
    logic signed [COORD_W-1:0] cc [NUM_LANES];
    logic signed [COORD_W-1:0] ce [NUM_LANES];
    logic signed [KW-1:0]      p0 [NUM_LANES];
    logic signed [KW-1:0]      p1 [NUM_LANES];
    logic [ACC_W-1:0]          dividend [NUM_LANES];
    logic [QUOT_W-1:0]         quot     [NUM_LANES];
    logic                      div_done [NUM_LANES];
    logic signed [COORD_W-1:0] sat_val  [NUM_LANES];

    logic signed [DW:0]        ds;
    logic signed [DW:0]        js;
    logic [ACC_W-1:0]          den;
    logic [ACC_W-1:0]          half;
    logic                      div_start;
    logic                      out_load;

    function automatic logic signed [COORD_W-1:0] sat16(
        input logic                neg,
        input logic [QUOT_W-1:0]   q
    );
        logic signed [QUOT_W:0] v;
        v = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
        if (v > (QUOT_W+1)'(32767))
        begin
            return 16'sh7FFF;
        end
        else if (v < -(QUOT_W+1)'(32768))
        begin
            return 16'sh8000;
        end
        return COORD_W'(v);
    endfunction

    assign ca[0] = job_reg.a.x;
    assign ca[1] = job_reg.a.y;
    assign cb[0] = job_reg.b.x;
    assign cb[1] = job_reg.b.y;
    assign cc[0] = job_reg.c.x;
    assign cc[1] = job_reg.c.y;
    assign ce[0] = job_reg.e.x;
    assign ce[1] = job_reg.e.y;

    assign ds        = $signed({1'b0, d});
    assign js        = $signed({1'b0, j_reg});
    assign den       = ACC_W'(d3_reg) << FRAC_BITS;
    assign half      = ACC_W'(d3_reg) << (FRAC_BITS - 1);
    assign div_start = (state_reg == S_DSTART);
    assign q_pop     = (state_reg == S_IDLE) && q_valid;
    assign out_load  = (state_reg == S_EMIT) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    for (genvar l = 0; l < NUM_LANES; l++)
    begin : g_lane
        assign p0[l] = KW'(cb[l]) <<< FRAC_BITS;
        assign p1[l] = KW'(cc[l]) <<< FRAC_BITS;
        assign dividend[l] = (acc_reg[l][ACC_W-1] ? ACC_W'(-acc_reg[l]) : ACC_W'(acc_reg[l]))
                             + half;
        assign sat_val[l] = sat16(neg_reg[l], quot[l]);

        cspg_divider u_div (
            .clk      (clk),
            .rst_n    (rst_n),
            .start    (div_start),
            .dividend (dividend[l]),
            .divisor  (den),
            .quotient (quot[l]),
            .done     (div_done[l])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            j_reg         <= '0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        state_reg <= S_D2;
                    end
                end
                S_D2:
                begin
                    state_reg <= S_D3;
                end
                S_D3:
                begin
                    state_reg <= S_TAN;
                end
                S_TAN:
                begin
                    state_reg <= S_COEF;
                end
                S_COEF:
                begin
                    state_reg <= S_PRE;
                end
                S_PRE:
                begin
                    j_reg     <= '0;
                    state_reg <= S_H1;
                end
                S_H1:
                begin
                    state_reg <= S_H2;
                end
                S_H2:
                begin
                    state_reg <= S_H3;
                end
                S_H3:
                begin
                    state_reg <= S_DSTART;
                end
                S_DSTART:
                begin
                    state_reg <= S_DWAIT;
                end
                S_DWAIT:
                begin
                    if (div_done[0] && div_done[1])
                    begin
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (out_load)
                    begin
                        if (j_reg == d)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            j_reg     <= j_reg + 1'b1;
                            state_reg <= S_H1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            job_reg <= q_job;
        end
        if (state_reg == S_D2)
        begin
            d2_reg <= d * d;
        end
        if (state_reg == S_D3)
        begin
            d3_reg <= d2_reg * d;
        end
        if (out_load)
        begin
            out_data_reg.pixel_x     <= sat_val[0];
            out_data_reg.pixel_y     <= sat_val[1];
            out_data_reg.segment_end <= (j_reg == d);
        end
        for (int l = 0; l < NUM_LANES; l++)
        begin
            case (state_reg)
                S_TAN:
                begin
                    t0_reg[l] <= TAN_W'(scale * (SCALE_W'(cc[l]) - SCALE_W'(ca[l])));
                    t1_reg[l] <= TAN_W'(scale * (SCALE_W'(ce[l]) - SCALE_W'(cb[l])));
                end
                S_COEF:
                begin
                    k3_reg[l] <= (p0[l] <<< 1) + KW'(t0_reg[l]) - (p1[l] <<< 1)
                                 + KW'(t1_reg[l]);
                    k2_reg[l] <= p1[l] * 3 - p0[l] * 3 - (KW'(t0_reg[l]) <<< 1)
                                 - KW'(t1_reg[l]);
                end
                S_PRE:
                begin
                    k2d_reg[l]   <= ACC_W'(k2_reg[l] * ds);
                    t0dd_reg[l]  <= ACC_W'(KW'(t0_reg[l]) * $signed({1'b0, d2_reg}));
                    p0ddd_reg[l] <= ACC_W'(p0[l] * $signed({1'b0, d3_reg}));
                end
                S_H1:
                begin
                    acc_reg[l] <= ACC_W'(k3_reg[l] * js) + k2d_reg[l];
                end
                S_H2:
                begin
                    acc_reg[l] <= ACC_W'(acc_reg[l] * js) + t0dd_reg[l];
                end
                S_H3:
                begin
                    acc_reg[l] <= ACC_W'(acc_reg[l] * js) + p0ddd_reg[l];
                end
                S_DSTART:
                begin
                    neg_reg[l] <= acc_reg[l][ACC_W-1];
                end
                default:
                begin
                end
            endcase
        end
    end

    a_j_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_H1) |-> (j_reg <= d))
        else $error("sample index beyond segment length");

    a_lanes_in_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DWAIT) |-> (div_done[0] == div_done[1]))
        else $error("x and y dividers out of step");

    a_segment_close: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && (j_reg == d)) |=>
            ((state_reg == S_IDLE) && out_valid_reg && out_data_reg.segment_end))
        else $error("last sample did not close the segment");

    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !q_pop)
        else $error("job taken while a segment is in progress");

endmodule

### rtl/core/cardinal_spline_point_generator.sv
// Cardinal spline point generator: control points in, rounded curve samples out.
// Holds the configuration registers; depends on cspg_pkg, cspg_front, cspg_queue, cspg_back.
// Every control point after the third of a spline produces one segment of N samples
// when N is at least two, N being points_per_segment limited to MAX_SEGMENT_POINTS; a
// point is accepted while the two-entry job queue has room. Each segment first computes
// d squared, d cubed, the tangents, the coefficients and the precomputed terms, then per
// sample runs three Horner steps, a 24-bit restoring divide per coordinate (x and y side
// by side) and a load of the output register, which waits on out_ready.
module cardinal_spline_point_generator #(
    parameter int MAX_SEGMENT_POINTS = cspg_pkg::MAX_SEGMENT_POINTS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  cspg_pkg::in_item_t             in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output cspg_pkg::out_item_t            out_data,
    input  logic                           cfg_we,
    input  logic [0:0]                     cfg_index,
    input  logic [cspg_pkg::CFG_W-1:0]     cfg_data
);
    import cspg_pkg::*;

    localparam int CW = $clog2(MAX_SEGMENT_POINTS + 1);
    localparam int DW = $clog2(MAX_SEGMENT_POINTS);
    localparam int EW = (CW > 7) ? CW : 7;

    logic [15:0]               tension_reg;
    logic [6:0]                pps_reg;
    logic [EW-1:0]             pps_ext;
    logic [CW-1:0]             n_eff;
    logic [DW-1:0]             d;
    logic signed [SCALE_W-1:0] scale;
    logic                      seg_enable;
    logic                      q_full;
    logic                      q_push;
    logic                      q_pop;
    logic                      q_valid;
    job_t                      push_job;
    job_t                      pop_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tension_reg <= TENSION_RESET;
            pps_reg     <= PPS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_TENSION:
                begin
                    tension_reg <= cfg_data[15:0];
                end
                REG_POINTS_PER_SEGMENT:
                begin
                    pps_reg <= cfg_data[6:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    assign pps_ext    = EW'(pps_reg);
    assign n_eff      = (pps_ext > EW'(MAX_SEGMENT_POINTS)) ? CW'(MAX_SEGMENT_POINTS)
                                                            : CW'(pps_ext);
    assign seg_enable = (n_eff >= CW'(2));
    assign d          = DW'(n_eff - 1'b1);
    assign scale      = ONE_Q14 - SCALE_W'($signed(tension_reg));

    cspg_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .seg_enable (seg_enable),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_job      (push_job)
    );

    cspg_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (push_job),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_valid),
        .pop_data   (pop_job)
    );

    cspg_back #(
        .MAX_SEGMENT_POINTS (MAX_SEGMENT_POINTS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_job      (pop_job),
        .scale      (scale),
        .d          (d),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule
